[rtl/core/timer_min_heap_queue_macros.svh]
// ----------------------------------------------------------------------------
// Timer queue assertion macros
// Shorthand for the concurrent checks on the queue's ports.
// ----------------------------------------------------------------------------
`ifndef TIMER_MIN_HEAP_QUEUE_MACROS_SVH
`define TIMER_MIN_HEAP_QUEUE_MACROS_SVH

// check outside reset
`define TMHQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check at every edge, reset included
`define TMHQ_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/tmhq_pkg.sv]
// ----------------------------------------------------------------------------
// Timer queue package
// Shared types, codes and the entry ordering for the timer queue.
// ----------------------------------------------------------------------------
package tmhq_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int MAX_FIRE      = 64;
  localparam int FIRE_W        = 7;

  typedef logic [1:0]  cmd_t;
  typedef logic [31:0] delay_t;
  typedef logic [63:0] expiry_t;
  typedef logic [31:0] id_t;
  typedef logic [7:0]  etype_t;
  typedef logic [1:0]  prio_t;
  typedef logic [1:0]  kind_t;
  typedef logic [1:0]  status_t;
  typedef logic [1:0]  cellop_t;

  localparam cmd_t CMD_SCHED  = 2'd0;
  localparam cmd_t CMD_TICK   = 2'd1;
  localparam cmd_t CMD_CANCEL = 2'd2;

  localparam kind_t KIND_SCHED  = 2'd0;
  localparam kind_t KIND_FIRE   = 2'd1;
  localparam kind_t KIND_CANCEL = 2'd2;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_FULL    = 2'd1;
  localparam status_t ST_MISSING = 2'd2;
  localparam status_t ST_ZERO    = 2'd3;

  localparam cellop_t OP_HOLD   = 2'd0;
  localparam cellop_t OP_INSERT = 2'd1;
  localparam cellop_t OP_REMOVE = 2'd2;

  typedef struct packed {
    expiry_t expiry;
    id_t     id;
    etype_t  etype;
    prio_t   prio;
  } entry_t;

  typedef struct packed {
    cellop_t op;
    entry_t  fresh;
    id_t     want;
  } cell_ctl_t;

  typedef struct packed {
    kind_t   kind;
    status_t status;
    id_t     number;
    etype_t  etype;
    prio_t   prio;
    logic    last;
  } out_word_t;

  function automatic logic entry_before(entry_t a, entry_t b);
    if (a.expiry != b.expiry) return a.expiry < b.expiry;
    return a.id < b.id;
  endfunction

endpackage

[rtl/core/tmhq_if.sv]
// ----------------------------------------------------------------------------
// Timer queue channels
// Request and reply channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tmhq_in_if import tmhq_pkg::*; ();
  logic   valid;
  logic   ready;
  cmd_t   cmd;
  delay_t delay;
  etype_t event_type;
  prio_t  event_priority;
  id_t    cancel_id;

  modport source (output valid, cmd, delay, event_type, event_priority, cancel_id,
                  input ready);
  modport sink (input valid, cmd, delay, event_type, event_priority, cancel_id,
                output ready);
endinterface

interface tmhq_out_if import tmhq_pkg::*; ();
  logic    valid;
  logic    ready;
  kind_t   kind;
  status_t status;
  id_t     timer_number;
  etype_t  fired_type;
  prio_t   fired_priority;
  logic    last;

  modport source (output valid, kind, status, timer_number, fired_type, fired_priority,
                  last, input ready);
  modport sink (input valid, kind, status, timer_number, fired_type, fired_priority,
                last, output ready);
endinterface

[rtl/core/tmhq_cell.sv]
// ----------------------------------------------------------------------------
// Timer queue cell
// One slot of the sorted row: compares against the broadcast entry and takes
// that entry or its left neighbour's on insert, its right neighbour's on removal.
// ----------------------------------------------------------------------------
module tmhq_cell import tmhq_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occupied,
  input  logic      drop,
  input  logic      left_ins,
  input  entry_t    left_entry,
  input  entry_t    right_entry,
  output logic      ins,
  output logic      match,
  output entry_t    entry
);

  assign ins   = !occupied || entry_before(ctl.fresh, entry);
  assign match = occupied && (entry.id == ctl.want);

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_INSERT: begin
        if (ins) begin
          entry <= left_ins ? left_entry : ctl.fresh;
        end
      end
      OP_REMOVE: begin
        if (drop) begin
          entry <= right_entry;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/core/tmhq_scan.sv]
// ----------------------------------------------------------------------------
// Timer queue match scan
// Turns the row of cancel matches into a prefix mask, doubling the span each
// cycle, so every cell at or after the first match is flagged.
// ----------------------------------------------------------------------------
module tmhq_scan import tmhq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic [DEPTH-1:0] hits,
  output logic [DEPTH-1:0] mask,
  output logic             busy
);

  localparam int STEPS = $clog2(DEPTH);
  localparam int SW    = $clog2(STEPS + 1);

  logic [SW-1:0] step;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (load) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + SW'(1);
      if (step == SW'(STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mask <= hits;
    end else if (busy) begin
      mask <= mask | (mask << (DEPTH'(1) << step));
    end
  end

endmodule

[rtl/core/timer_min_heap_queue.sv]
// ----------------------------------------------------------------------------
// Timer queue: a sorted row of cells, earliest expiry in cell 0; one word at a time.
// Schedule, cancel of id zero: the reply is registered from S_SCHED or S_CANCEL, then
// back to idle. Cancel: S_CANCEL loads the scan, S_SCAN waits on it, S_DROP replies.
// Tick: fired words from S_TICK, one per cycle while the reply channel takes them,
// then idle. Reply stalls hold the state. Reset empties the queue, next id 1, clock 0.
// ----------------------------------------------------------------------------
module timer_min_heap_queue import tmhq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEPTH_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  tmhq_in_if.sink   request,
  tmhq_out_if.source reply
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCHED  = 3'd1;
  localparam logic [2:0] S_TICK   = 3'd2;
  localparam logic [2:0] S_CANCEL = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_DROP   = 3'd5;

  logic [2:0]        state, state_next;
  logic [CW-1:0]     count;
  id_t               next_id;
  expiry_t           now;
  logic [FIRE_W-1:0] fire_n;
  expiry_t           expiry_r;
  etype_t            type_r;
  prio_t             prio_r;
  id_t               want_r;

  logic      out_valid;
  out_word_t out_word;
  logic      out_free, emit;
  out_word_t word;
  cellop_t   op;
  logic      pop, scan_load, scan_busy;
  logic      head_due, more_due, found;
  cell_ctl_t ctl;

  entry_t                 cells [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] ins, match, occ, drop, mask;

  assign out_free = !out_valid || reply.ready;
  assign request.ready = (state == S_IDLE);

  assign ctl.op          = op;
  assign ctl.fresh       = '{expiry: expiry_r, id: next_id, etype: type_r, prio: prio_r};
  assign ctl.want        = want_r;

  assign drop = pop ? '1 : mask;
  assign found = mask[QUEUE_DEPTH-1];

  assign head_due = (count != '0) && (cells[0].expiry <= now)
                    && (fire_n < FIRE_W'(MAX_FIRE));
  assign more_due = (count > CW'(1)) && (cells[1].expiry <= now)
                    && (fire_n < FIRE_W'(MAX_FIRE - 1));

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign occ[i] = CW'(i) < count;
    tmhq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (occ[i]),
      .drop       (drop[i]),
      .left_ins   ((i == 0) ? 1'b0 : ins[(i == 0) ? 0 : i - 1]),
      .left_entry (cells[(i == 0) ? 0 : i - 1]),
      .right_entry(cells[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
      .ins        (ins[i]),
      .match      (match[i]),
      .entry      (cells[i])
    );
  end

  tmhq_scan #(.DEPTH(QUEUE_DEPTH)) u_scan (
    .clk (clk),
    .rst (rst),
    .load(scan_load),
    .hits(match),
    .mask(mask),
    .busy(scan_busy)
  );

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    word       = '0;
    op         = OP_HOLD;
    pop        = 1'b0;
    scan_load  = 1'b0;
    case (state)
      S_IDLE: begin
        if (request.valid) begin
          case (request.cmd)
            CMD_SCHED:  state_next = S_SCHED;
            CMD_TICK:   state_next = S_TICK;
            CMD_CANCEL: state_next = S_CANCEL;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_SCHED: begin
        if (out_free) begin
          emit        = 1'b1;
          state_next  = S_IDLE;
          word.kind   = KIND_SCHED;
          word.last   = 1'b1;
          if (count >= FULL) begin
            word.status = ST_FULL;
          end else begin
            word.status = ST_OK;
            word.number = next_id;
            op          = OP_INSERT;
          end
        end
      end
      S_TICK: begin
        if (!head_due) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          emit        = 1'b1;
          word.kind   = KIND_FIRE;
          word.status = ST_OK;
          word.number = cells[0].id;
          word.etype  = cells[0].etype;
          word.prio   = cells[0].prio;
          word.last   = !more_due;
          op          = OP_REMOVE;
          pop         = 1'b1;
        end
      end
      S_CANCEL: begin
        if (want_r == '0) begin
          if (out_free) begin
            emit        = 1'b1;
            word.kind   = KIND_CANCEL;
            word.status = ST_ZERO;
            word.last   = 1'b1;
            state_next  = S_IDLE;
          end
        end else begin
          scan_load  = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!scan_busy) state_next = S_DROP;
      end
      S_DROP: begin
        if (out_free) begin
          emit        = 1'b1;
          word.kind   = KIND_CANCEL;
          word.number = want_r;
          word.last   = 1'b1;
          word.status = found ? ST_OK : ST_MISSING;
          op          = found ? OP_REMOVE : OP_HOLD;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      next_id   <= 32'd1;
      now       <= '0;
      fire_n    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (request.valid && request.ready) begin
        fire_n <= '0;
        if (request.cmd == CMD_TICK) now <= now + 64'd1;
      end else if (pop) begin
        fire_n <= fire_n + FIRE_W'(1);
      end
      if (op == OP_INSERT) begin
        count   <= count + CW'(1);
        next_id <= (next_id == '1) ? 32'd1 : next_id + 32'd1;
      end else if (op == OP_REMOVE) begin
        count <= count - CW'(1);
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (reply.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (request.valid && request.ready) begin
      expiry_r <= now + 64'(request.delay);
      type_r   <= request.event_type;
      prio_r   <= request.event_priority;
      want_r   <= request.cancel_id;
    end
    if (emit) out_word <= word;
  end

  assign reply.valid          = out_valid;
  assign reply.kind           = out_word.kind;
  assign reply.status         = out_word.status;
  assign reply.timer_number   = out_word.number;
  assign reply.fired_type     = out_word.etype;
  assign reply.fired_priority = out_word.prio;
  assign reply.last           = out_word.last;

endmodule

[rtl/core/tmhq_checker.sv]
// ----------------------------------------------------------------------------
// Timer queue port checker
// Watches the reply channel for reset, hold and field consistency.
// ----------------------------------------------------------------------------
`include "timer_min_heap_queue_macros.svh"

module tmhq_checker import tmhq_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    out_valid,
  input logic    out_ready,
  input kind_t   out_kind,
  input status_t out_status,
  input id_t     out_number,
  input etype_t  out_type,
  input prio_t   out_prio
);

  `TMHQ_ASSERT_ALWAYS(a_reset_idle, rst |=> !out_valid, "reply word after reset")
  `TMHQ_ASSERT(a_valid_hold, out_valid && !out_ready |=> out_valid, "reply word dropped")
  `TMHQ_ASSERT(a_sched_id, out_valid && out_kind == KIND_SCHED && out_status == ST_OK |-> out_number != '0, "zero id granted")
  `TMHQ_ASSERT(a_fire_ok, out_valid && out_kind == KIND_FIRE |-> out_status == ST_OK, "fired word with bad status")
  `TMHQ_ASSERT(a_reply_clean, out_valid && out_kind != KIND_FIRE |-> out_type == '0 && out_prio == '0, "reply carries event fields")

endmodule

bind timer_min_heap_queue tmhq_checker u_tmhq_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (reply.valid),
  .out_ready (reply.ready),
  .out_kind  (reply.kind),
  .out_status(reply.status),
  .out_number(reply.timer_number),
  .out_type  (reply.fired_type),
  .out_prio  (reply.fired_priority)
);
